// ===== hw/rtl/stsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared constants and types for the subarray target sum counter.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VALUE_W     = 16;
  localparam int SUM_W       = 27;
  localparam int TOTAL_W     = 20;
  localparam int CNT_W       = 11;
  localparam int SEEN_W      = $clog2(MAX_LEN) + 1;
  localparam int EPOCH_W     = 8;

  // multiplicative hash: slot is product bits [HASH_SHIFT +: ADDR_W]
  localparam int HASH_SHIFT = 7;
  localparam int HASH_W     = HASH_SHIFT + ADDR_W;
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [SUM_W-1:0]   key;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/stsc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_in_if
// Input item channel: one signed sequence element and its last mark.
// ----------------------------------------------------------------------------
interface stsc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [stsc_pkg::VALUE_W-1:0] value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hw/rtl/stsc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_out_if
// Result item channel: match count and overflow flag of one sequence.
// ----------------------------------------------------------------------------
interface stsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [stsc_pkg::TOTAL_W-1:0] match_count;
  logic                         overflow;

  modport source (output valid, output match_count, output overflow, input ready);
  modport sink   (input valid, input match_count, input overflow, output ready);
endinterface

// ===== hw/rtl/stsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stsc_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_hash
// Multiplicative hash of a prefix key to its home slot in the table.
// ----------------------------------------------------------------------------
module stsc_hash (
  input  logic [stsc_pkg::SUM_W-1:0]  key,
  output logic [stsc_pkg::ADDR_W-1:0] slot
);

  logic [2*stsc_pkg::HASH_W-1:0] prod;

  // only the low product bits reach the slot, so narrow operands suffice
  assign prod = {{stsc_pkg::HASH_W{1'b0}}, key[stsc_pkg::HASH_W-1:0]}
              * {{stsc_pkg::HASH_W{1'b0}}, stsc_pkg::HASH_MULT[stsc_pkg::HASH_W-1:0]};
  assign slot = prod[stsc_pkg::HASH_SHIFT +: stsc_pkg::ADDR_W];

endmodule

// ===== hw/rtl/subarray_target_sum_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subarray_target_sum_counter
// Counts contiguous runs of a signed sequence that sum to a target value.
// ----------------------------------------------------------------------------
// One item at a time. Each item within the 1024-item limit runs a lookup
// of its key (hash, read, check), then an insert of its prefix sum (hash,
// read, check); every further linear probe repeats the read and check, paced
// by the single table RAM with its registered read. The item marked last then
// passes S_FIN to deliver the result and S_SEED to reseed the table. Entries
// are tagged with a sequence epoch; after reset and once every 255 sequences
// a clearing pass sweeps all 2048 table entries, during which no item is
// taken. A result waits in an output register while the next items are taken.
module subarray_target_sum_counter (
  input  logic                               clk,
  input  logic                               rst,
  stsc_in_if.sink                            in_ch,
  stsc_out_if.source                         out_ch,
  input  logic                               cfg_wr_en,
  input  logic signed [stsc_pkg::SUM_W-1:0]  cfg_wr_data
);

  typedef enum logic [3:0] {
    S_CLR, S_SEED, S_IDLE, S_L_HASH, S_L_RD, S_L_CHK,
    S_I_HASH, S_I_RD, S_I_CHK, S_FIN
  } state_t;

  localparam logic [stsc_pkg::ADDR_W-1:0]  LAST_ADDR = stsc_pkg::ADDR_W'(stsc_pkg::TABLE_DEPTH - 1);
  localparam logic [stsc_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [stsc_pkg::CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [stsc_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  state_t                        state;
  logic [stsc_pkg::EPOCH_W-1:0]  epoch;
  logic [stsc_pkg::SUM_W-1:0]    target;
  logic [stsc_pkg::SUM_W-1:0]    running_sum;
  logic [stsc_pkg::TOTAL_W-1:0]  total;
  logic [stsc_pkg::SEEN_W-1:0]   items_seen;
  logic                          overflowed;
  logic                          is_last;
  logic [stsc_pkg::SUM_W-1:0]    key_q;
  logic [stsc_pkg::ADDR_W-1:0]   addr;
  logic [stsc_pkg::ADDR_W-1:0]   probes;

  logic [stsc_pkg::SUM_W-1:0]    sum_next;
  logic [stsc_pkg::ADDR_W-1:0]   home;
  logic                          we;
  logic [stsc_pkg::ADDR_W-1:0]   waddr;
  stsc_pkg::entry_t              wentry;
  stsc_pkg::entry_t              rentry;
  logic                          ent_vld;
  logic                          ent_hit;
  logic [stsc_pkg::TOTAL_W:0]    total_sum;

  // prefix table
  stsc_ram #(
    .WIDTH (stsc_pkg::ENTRY_W),
    .DEPTH (stsc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (addr),
    .rdata (rentry)
  );

  stsc_hash u_hash (
    .key  (key_q),
    .slot (home)
  );

  // probe compare and datapath sums
  assign sum_next  = running_sum
                   + {{(stsc_pkg::SUM_W-stsc_pkg::VALUE_W){in_ch.value[stsc_pkg::VALUE_W-1]}},
                      in_ch.value};
  assign ent_vld   = (rentry.epoch == epoch);
  assign ent_hit   = ent_vld && (rentry.key == key_q);
  assign total_sum = {1'b0, total} + {{(stsc_pkg::TOTAL_W+1-stsc_pkg::CNT_W){1'b0}}, rentry.cnt};

  assign in_ch.ready = (state == S_IDLE);

  // table write port
  always_comb begin
    we     = 1'b0;
    waddr  = addr;
    wentry = '0;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_SEED: begin
        we           = 1'b1;
        waddr        = '0;
        wentry.epoch = epoch;
        wentry.cnt   = stsc_pkg::CNT_W'(1);
      end
      S_I_CHK: begin
        wentry.epoch = epoch;
        wentry.key   = key_q;
        if (!ent_vld) begin
          we         = 1'b1;
          wentry.cnt = stsc_pkg::CNT_W'(1);
        end else if (ent_hit) begin
          we         = 1'b1;
          wentry.cnt = (rentry.cnt == CNT_MAX) ? CNT_MAX : rentry.cnt + 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_wr_en) begin
      target <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      epoch        <= stsc_pkg::EPOCH_W'(1);
      running_sum  <= '0;
      total        <= '0;
      items_seen   <= '0;
      overflowed   <= 1'b0;
      is_last      <= 1'b0;
      addr         <= '0;
      probes       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // result taken; a result loaded in S_FIN keeps valid high
      if (out_ch.valid && out_ch.ready && state != S_FIN) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ADDR) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            is_last <= in_ch.last;
            if (items_seen >= stsc_pkg::SEEN_W'(stsc_pkg::MAX_LEN)) begin
              overflowed <= 1'b1;
              state      <= in_ch.last ? S_FIN : S_IDLE;
            end else begin
              items_seen  <= items_seen + 1'b1;
              running_sum <= sum_next;
              key_q       <= sum_next - target;
              state       <= S_L_HASH;
            end
          end
        end
        S_L_HASH, S_I_HASH: begin
          addr   <= home;
          probes <= '0;
          state  <= (state == S_L_HASH) ? S_L_RD : S_I_RD;
        end
        S_L_RD: begin
          state <= S_L_CHK;
        end
        S_I_RD: begin
          state <= S_I_CHK;
        end
        S_L_CHK: begin
          if (!ent_vld || ent_hit || probes == LAST_ADDR) begin
            if (ent_hit) begin
              total <= total_sum[stsc_pkg::TOTAL_W] ? TOTAL_MAX
                                                    : total_sum[stsc_pkg::TOTAL_W-1:0];
            end
            key_q <= running_sum;
            state <= S_I_HASH;
          end else begin
            addr   <= addr + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_L_RD;
          end
        end
        S_I_CHK: begin
          if (!ent_vld || ent_hit || probes == LAST_ADDR) begin
            if (ent_vld && !ent_hit) begin
              overflowed <= 1'b1;
            end
            state <= is_last ? S_FIN : S_IDLE;
          end else begin
            addr   <= addr + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_I_RD;
          end
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid       <= 1'b1;
            out_ch.match_count <= total;
            out_ch.overflow    <= overflowed;
            running_sum        <= '0;
            total              <= '0;
            items_seen         <= '0;
            overflowed         <= 1'b0;
            addr               <= '0;
            if (epoch == EPOCH_MAX) begin
              epoch <= stsc_pkg::EPOCH_W'(1);
              state <= S_CLR;
            end else begin
              epoch <= epoch + 1'b1;
              state <= S_SEED;
            end
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subarray target sum counter: a directed table
// of short sequences, then random sequences under several target settings,
// with random idling on both channels. Each result is compared with a listed
// total or with a prefix-sum predictor that mirrors the hashed prefix table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_WAIT  = 2200;
  localparam int LONG_HOLD    = 1500;
  localparam int ITEMS_PER_PH = 190;
  localparam logic [stsc_pkg::TOTAL_W-1:0] TOTAL_SAT = '1;
  localparam logic [stsc_pkg::CNT_W-1:0]   COUNT_SAT = '1;

  typedef struct {
    logic [stsc_pkg::TOTAL_W-1:0] count;
    logic                         ovf;
  } total_t;

  typedef struct {
    logic signed [stsc_pkg::VALUE_W-1:0] value;
    logic                                last;
    bit                                  typed;
    logic [stsc_pkg::TOTAL_W-1:0]        count;
    logic                                ovf;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic signed [stsc_pkg::SUM_W-1:0] cfg_wr_data;

  stsc_in_if  in_if ();
  stsc_out_if out_if ();

  subarray_target_sum_counter i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // prefix-sum mirror of the block
  logic [stsc_pkg::SUM_W-1:0]   tgt;
  logic [stsc_pkg::SUM_W-1:0]   psum;
  logic [stsc_pkg::TOTAL_W-1:0] run_total;
  int                           taken;
  logic                         dropped;
  bit                           slot_used [stsc_pkg::TABLE_DEPTH];
  logic [stsc_pkg::SUM_W-1:0]   slot_sum  [stsc_pkg::TABLE_DEPTH];
  logic [stsc_pkg::CNT_W-1:0]   slot_hits [stsc_pkg::TABLE_DEPTH];

  total_t pending_totals[$];
  int     errs;
  int     totals_seen;
  int     items_taken;
  bit     idle_en;
  bit     hold_req;
  int     cycles;

  // home slot from the multiplicative hash
  function automatic int home_of(logic [stsc_pkg::SUM_W-1:0] key);
    logic [63:0] prod;
    prod = {37'd0, key} * 64'h0000_0000_9E37_79B1;
    prod = prod >> stsc_pkg::HASH_SHIFT;
    return int'(prod % stsc_pkg::TABLE_DEPTH);
  endfunction

  // slot of key or first free slot on its path; TABLE_DEPTH when full
  function automatic int find_slot(logic [stsc_pkg::SUM_W-1:0] key);
    int idx;
    idx = home_of(key);
    for (int n = 0; n < stsc_pkg::TABLE_DEPTH; n++) begin
      if (!slot_used[idx] || slot_sum[idx] == key) return idx;
      idx = (idx + 1) % stsc_pkg::TABLE_DEPTH;
    end
    return stsc_pkg::TABLE_DEPTH;
  endfunction

  function automatic void add_prefix(logic [stsc_pkg::SUM_W-1:0] key);
    int idx;
    idx = find_slot(key);
    if (idx == stsc_pkg::TABLE_DEPTH) begin
      dropped = 1'b1;
    end else if (slot_used[idx]) begin
      if (slot_hits[idx] != COUNT_SAT) slot_hits[idx]++;
    end else begin
      slot_used[idx] = 1'b1;
      slot_sum[idx]  = key;
      slot_hits[idx] = 1;
    end
  endfunction

  function automatic void new_sequence();
    for (int i = 0; i < stsc_pkg::TABLE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_sum[i]  = '0;
      slot_hits[i] = '0;
    end
    psum      = '0;
    run_total = '0;
    taken     = 0;
    dropped   = 1'b0;
    add_prefix('0);
  endfunction

  // one accepted item; returns 1 with the total when it closes a sequence
  function automatic bit count_runs(logic signed [stsc_pkg::VALUE_W-1:0] v, logic l,
                                    output total_t res);
    logic [stsc_pkg::SUM_W-1:0] key;
    logic [stsc_pkg::TOTAL_W:0] acc;
    int idx;
    if (taken >= stsc_pkg::MAX_LEN) begin
      dropped = 1'b1;
    end else begin
      taken++;
      psum = psum + stsc_pkg::SUM_W'(v);
      key  = psum - tgt;
      idx  = find_slot(key);
      if (idx < stsc_pkg::TABLE_DEPTH && slot_used[idx]) begin
        acc = {1'b0, run_total} + slot_hits[idx];
        run_total = (acc > TOTAL_SAT) ? TOTAL_SAT : acc[stsc_pkg::TOTAL_W-1:0];
      end
      add_prefix(psum);
    end
    res.count = run_total;
    res.ovf   = dropped;
    if (!l) return 0;
    new_sequence();
    return 1;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: ready with random hold-offs, one long one on request
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = idle_en ? $urandom_range(0, 7) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // result check against the oldest expected total
  always @(posedge clk) begin
    total_t exp_t;
    if (!rst && out_if.valid && out_if.ready) begin
      totals_seen++;
      if (pending_totals.size() == 0) begin
        $error("unexpected result: match_count %0d overflow %0b",
               out_if.match_count, out_if.overflow);
        errs++;
      end else begin
        exp_t = pending_totals.pop_front();
        if (out_if.match_count !== exp_t.count) begin
          $error("match_count: expected %0d, actual %0d", exp_t.count,
                 out_if.match_count);
          errs++;
        end
        if (out_if.overflow !== exp_t.ovf) begin
          $error("overflow: expected %0b, actual %0b", exp_t.ovf, out_if.overflow);
          errs++;
        end
      end
    end
  end

  // offer one item and record what it should produce
  task automatic offer_item(input logic signed [stsc_pkg::VALUE_W-1:0] v, input logic l,
                            input bit typed, input logic [stsc_pkg::TOTAL_W-1:0] tc,
                            input logic to);
    int gap;
    total_t res;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= l;
    do @(posedge clk); while (!in_if.ready);
    items_taken++;
    if (items_taken % 150 == 0) idle_en = ($urandom_range(0, 3) != 0);
    if (count_runs(v, l, res)) begin
      if (typed) begin
        res.count = tc;
        res.ovf   = to;
      end
      pending_totals.push_back(res);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  // target write once the block has gone quiet
  task automatic set_target(input logic signed [stsc_pkg::SUM_W-1:0] t);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tgt = t;
  endtask

  function automatic logic signed [stsc_pkg::VALUE_W-1:0] pick_value();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) return stsc_pkg::VALUE_W'($signed($urandom_range(0, 6)) - 3);
    if (mode < 9) return stsc_pkg::VALUE_W'($urandom);
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  // random sequences, mostly short, a few longer, some broken up with extremes
  task automatic random_phase(input int budget, input bit with_long);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) offer_item(pick_value(), i == len - 1, 0, '0, 0);
      sent += len;
      if (sent > budget / 2 && sent - len <= budget / 2) begin
        if (with_long) begin
          // over capacity: zeros give the largest count, extra items drop
          for (int i = 0; i < stsc_pkg::MAX_LEN + 6; i++)
            offer_item('0, i == stsc_pkg::MAX_LEN + 5, 0, '0, 0);
          hold_req = 1'b1;
        end else begin
          drain();
        end
      end
    end
  endtask

  row_t rows[$];

  // stimulus
  initial begin
    logic signed [stsc_pkg::SUM_W-1:0] targets[5];
    rst          = 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    in_if.last   <= 1'b0;
    errs         = 0;
    totals_seen  = 0;
    items_taken  = 0;
    idle_en      = 1'b1;
    hold_req     = 1'b0;
    tgt          = '0;
    new_sequence();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset target of zero
    rows = '{
      '{16'sd0,      1'b1, 1, 20'd1, 1'b0},
      '{16'sh7FFF,   1'b1, 1, 20'd0, 1'b0},
      '{16'sh8000,   1'b1, 1, 20'd0, 1'b0},
      '{16'sd5,      1'b0, 0, 20'd0, 1'b0},
      '{-16'sd5,     1'b1, 1, 20'd1, 1'b0},
      '{16'sd1,      1'b0, 0, 20'd0, 1'b0},
      '{-16'sd1,     1'b0, 0, 20'd0, 1'b0},
      '{16'sd1,      1'b0, 0, 20'd0, 1'b0},
      '{-16'sd1,     1'b1, 1, 20'd4, 1'b0},
      '{16'sd0,      1'b0, 0, 20'd0, 1'b0},
      '{16'sd0,      1'b0, 0, 20'd0, 1'b0},
      '{16'sd0,      1'b1, 1, 20'd6, 1'b0},
      '{16'sh7FFF,   1'b0, 0, 20'd0, 1'b0},
      '{16'sh7FFF,   1'b0, 0, 20'd0, 1'b0},
      '{16'sh8000,   1'b0, 0, 20'd0, 1'b0},
      '{-16'sd1,     1'b1, 0, 20'd0, 1'b0},
      '{16'sh8000,   1'b0, 0, 20'd0, 1'b0},
      '{16'sh8000,   1'b0, 0, 20'd0, 1'b0},
      '{16'sd100,    1'b1, 0, 20'd0, 1'b0}
    };
    foreach (rows[i])
      offer_item(rows[i].value, rows[i].last, rows[i].typed, rows[i].count, rows[i].ovf);

    // random phases across targets, extremes included
    targets = '{27'sd3, -27'sd1, 27'sh3FFFFFF, -27'sh4000000, 27'sd0};
    foreach (targets[p]) begin
      set_target(targets[p]);
      random_phase(ITEMS_PER_PH, p == 4);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d items and %0d sequence totals over 6 target settings,",
             items_taken, totals_seen);
    $display("including an over-capacity run and a long result-side hold-off");
    if (errs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/stsc_pkg.sv
hw/rtl/stsc_in_if.sv
hw/rtl/stsc_out_if.sv
hw/rtl/stsc_ram.sv
hw/rtl/stsc_hash.sv
hw/rtl/subarray_target_sum_counter.sv
bench/tb_top.sv
